### rtl/jlrs_pkg.sv
// ----------------------------------------------------------------------------
// jlrs_pkg
// Types and fixed codes shared by the journal replay sequencer modules.
// ----------------------------------------------------------------------------
package jlrs_pkg;

	// journal format constants
	localparam logic [31:0] JMAGIC           = 32'h4A52_4E4C;
	localparam int          JHDR_BYTES       = 8;
	localparam int          RHDR_BYTES       = 4;
	localparam int          COMMIT_REC_BYTES = 4;
	localparam int          DATA_HDR_BYTES   = 8;

	// input opcodes
	localparam logic OP_START  = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	// record kinds
	localparam logic [15:0] RT_DATA   = 16'd1;
	localparam logic [15:0] RT_COMMIT = 16'd2;

	// configuration register indexes
	localparam int   CFG_IDX_W         = 1;
	localparam logic REG_JOURNAL_START = 1'b0;
	localparam logic REG_TOTAL_BLOCKS  = 1'b1;

	// result status codes
	localparam logic [3:0] ST_STARTED  = 4'd0;
	localparam logic [3:0] ST_INVALID  = 4'd1;
	localparam logic [3:0] ST_QUEUED   = 4'd2;
	localparam logic [3:0] ST_SKIPPED  = 4'd3;
	localparam logic [3:0] ST_WRITE    = 4'd4;
	localparam logic [3:0] ST_EMPTY    = 4'd5;
	localparam logic [3:0] ST_STOPPED  = 4'd6;
	localparam logic [3:0] ST_OVERFLOW = 4'd7;
	localparam logic [3:0] ST_IGNORED  = 4'd8;

	// replay phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_STOP = 2'd2
	} phase_t;

	// controller states
	typedef enum logic [1:0] {
		C_ACCEPT = 2'd0,
		C_EVAL   = 2'd1,
		C_READ   = 2'd2,
		C_EMIT   = 2'd3
	} ctl_state_t;

	// input beat
	typedef struct packed {
		logic        opcode;
		logic [31:0] header_magic;
		logic [31:0] header_bytes_used;
		logic [15:0] record_type;
		logic [15:0] record_size;
		logic [31:0] target_block;
	} jlrs_in_t;

	// result beat
	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] dest_block;
		logic [16:0] payload_offset;
		logic        last;
		logic [13:0] transactions;
	} jlrs_out_t;

	// one pending write queue entry
	typedef struct packed {
		logic [31:0] blk;
		logic [16:0] off;
	} jlrs_pend_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic evaluate;
		logic rd_issue;
		logic emit;
	} jlrs_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic drain;
		logic drain_last;
	} jlrs_sts_t;

endpackage

### rtl/jlrs_ctrl.sv
// ----------------------------------------------------------------------------
// jlrs_ctrl
// Sequencer for the replay: input capture, header evaluation and the commit
// drain of the pending write queue.
// ----------------------------------------------------------------------------
module jlrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  jlrs_pkg::jlrs_sts_t sts,
	output jlrs_pkg::jlrs_cmd_t cmd
);
	import jlrs_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_ACCEPT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			C_ACCEPT: begin
				if (in_valid) state_nxt = C_EVAL;
			end
			C_EVAL: begin
				if (sts.out_free) state_nxt = sts.drain ? C_READ : C_ACCEPT;
			end
			C_READ: begin
				state_nxt = C_EMIT;
			end
			C_EMIT: begin
				if (sts.out_free) state_nxt = sts.drain_last ? C_ACCEPT : C_READ;
			end
			default: begin
				state_nxt = C_ACCEPT;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			C_ACCEPT: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			C_EVAL: begin
				cmd.evaluate = sts.out_free;
			end
			C_READ: begin
				cmd.rd_issue = 1'b1;
			end
			C_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### rtl/jlrs_dp.sv
// ----------------------------------------------------------------------------
// jlrs_dp
// Replay datapath: configuration registers, replay state, header checks,
// pending write queue memory and the result register.
// ----------------------------------------------------------------------------
module jlrs_dp #(
	parameter int PENDING_DEPTH       = 64,
	parameter int JOURNAL_BLOCK_COUNT = 16,
	parameter int BLOCK_BYTES         = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jlrs_pkg::jlrs_cmd_t            cmd,
	output jlrs_pkg::jlrs_sts_t            sts,
	input  jlrs_pkg::jlrs_in_t             in_data,
	output jlrs_pkg::jlrs_out_t            out_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           cfg_valid,
	input  logic [jlrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import jlrs_pkg::*;

	localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
	localparam int AW            = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int JOURNAL_BYTES = JOURNAL_BLOCK_COUNT * BLOCK_BYTES;
	localparam int DATA_REC_BYTES = DATA_HDR_BYTES + BLOCK_BYTES;

	// configuration
	logic [31:0] journal_start_q;
	logic [31:0] total_blocks_q;

	// replay state
	phase_t           phase_q;
	logic [16:0]      log_offset_q;
	logic [31:0]      log_bytes_used_q;
	logic [CNT_W-1:0] pend_cnt_q;
	logic [13:0]      commit_cnt_q;
	logic [CNT_W-1:0] drain_idx_q;

	// captured input, queue memory and read data
	jlrs_in_t   in_q;
	jlrs_pend_t pend_mem [PENDING_DEPTH];
	jlrs_pend_t rd_data_q;

	// result register
	jlrs_out_t out_q;
	logic      out_valid_q;

	// header checks
	logic        start_ok;
	logic        ignore;
	logic        hdr_past_journal;
	logic        bad_type;
	logic        bad_size;
	logic [17:0] rec_end;
	logic        past_used;
	logic        bad_hdr;
	logic [32:0] area_end;
	logic        in_area;
	logic        tgt_ok;
	logic        queue_full;
	logic [3:0]  st_sel;
	logic [13:0] commit_inc;

	always_comb begin
		start_ok = (in_q.header_magic == JMAGIC)
			&& (in_q.header_bytes_used >= 32'(JHDR_BYTES))
			&& (in_q.header_bytes_used <= 32'(JOURNAL_BYTES));
		ignore = (phase_q != PH_RUN) || ({15'd0, log_offset_q} >= log_bytes_used_q);
		hdr_past_journal = (18'(log_offset_q) + 18'(RHDR_BYTES)) > 18'(JOURNAL_BYTES);
		bad_type = (in_q.record_type != RT_DATA) && (in_q.record_type != RT_COMMIT);
		bad_size = ((in_q.record_type == RT_DATA)
				&& (in_q.record_size != 16'(DATA_REC_BYTES)))
			|| ((in_q.record_type == RT_COMMIT)
				&& (in_q.record_size != 16'(COMMIT_REC_BYTES)))
			|| (in_q.record_size == 16'd0);
		rec_end   = 18'(log_offset_q) + 18'(in_q.record_size);
		past_used = {14'd0, rec_end} > log_bytes_used_q;
		bad_hdr   = hdr_past_journal || bad_type || bad_size || past_used;
		// target must be non-zero, outside the journal area and on the device
		area_end  = 33'(journal_start_q) + 33'(JOURNAL_BLOCK_COUNT);
		in_area   = (in_q.target_block >= journal_start_q)
			&& ({1'b0, in_q.target_block} < area_end);
		tgt_ok    = (in_q.target_block != 32'd0) && !in_area
			&& (in_q.target_block < total_blocks_q);
		queue_full = pend_cnt_q >= CNT_W'(PENDING_DEPTH);
		commit_inc = commit_cnt_q + 14'd1;
	end

	// outcome of the captured beat
	always_comb begin
		if (in_q.opcode == OP_START) begin
			st_sel = start_ok ? ST_STARTED : ST_INVALID;
		end else if (ignore) begin
			st_sel = ST_IGNORED;
		end else if (bad_hdr) begin
			st_sel = ST_STOPPED;
		end else if (in_q.record_type == RT_DATA) begin
			if (!tgt_ok) st_sel = ST_SKIPPED;
			else if (queue_full) st_sel = ST_OVERFLOW;
			else st_sel = ST_QUEUED;
		end else begin
			st_sel = (pend_cnt_q == '0) ? ST_EMPTY : ST_WRITE;
		end
	end

	// status to controller
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.drain      = (st_sel == ST_WRITE);
	assign sts.drain_last = ((drain_idx_q + CNT_W'(1)) == pend_cnt_q);

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			journal_start_q  <= 32'd1;
			total_blocks_q   <= 32'd64;
			phase_q          <= PH_IDLE;
			log_offset_q     <= 17'(JHDR_BYTES);
			log_bytes_used_q <= 32'd0;
			pend_cnt_q       <= '0;
			commit_cnt_q     <= 14'd0;
			drain_idx_q      <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			// register writes
			if (cfg_valid) begin
				if (cfg_index == REG_JOURNAL_START) journal_start_q <= cfg_data;
				else total_blocks_q <= cfg_data;
			end
			// result beat handshake: a new load wins over the take
			if ((cmd.evaluate && (st_sel != ST_WRITE)) || cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			// header evaluation
			if (cmd.evaluate) begin
				case (st_sel)
					ST_STARTED: begin
						phase_q          <= PH_RUN;
						log_offset_q     <= 17'(JHDR_BYTES);
						log_bytes_used_q <= in_q.header_bytes_used;
						pend_cnt_q       <= '0;
						commit_cnt_q     <= 14'd0;
					end
					ST_INVALID: begin
						phase_q    <= PH_IDLE;
						pend_cnt_q <= '0;
					end
					ST_STOPPED, ST_OVERFLOW: begin
						phase_q    <= PH_STOP;
						pend_cnt_q <= '0;
					end
					ST_SKIPPED: begin
						log_offset_q <= rec_end[16:0];
					end
					ST_QUEUED: begin
						log_offset_q <= rec_end[16:0];
						pend_cnt_q   <= pend_cnt_q + CNT_W'(1);
					end
					ST_EMPTY: begin
						log_offset_q <= rec_end[16:0];
						commit_cnt_q <= commit_inc;
					end
					ST_WRITE: begin
						log_offset_q <= rec_end[16:0];
						commit_cnt_q <= commit_inc;
						drain_idx_q  <= '0;
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
			// commit drain step
			if (cmd.emit) begin
				drain_idx_q <= drain_idx_q + CNT_W'(1);
				if (sts.drain_last) pend_cnt_q <= '0;
			end
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= in_data;
	end

	// pending write queue
	always_ff @(posedge clk) begin
		if (cmd.evaluate && (st_sel == ST_QUEUED)) begin
			pend_mem[pend_cnt_q[AW-1:0]] <= '{blk: in_q.target_block, off: log_offset_q};
		end
		if (cmd.rd_issue) rd_data_q <= pend_mem[drain_idx_q[AW-1:0]];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status         <= ST_WRITE;
			out_q.dest_block     <= rd_data_q.blk;
			out_q.payload_offset <= rd_data_q.off;
			out_q.last           <= sts.drain_last;
			out_q.transactions   <= commit_cnt_q;
		end else if (cmd.evaluate && (st_sel != ST_WRITE)) begin
			out_q.status         <= st_sel;
			out_q.dest_block     <= 32'd0;
			out_q.payload_offset <= (st_sel == ST_QUEUED) ? log_offset_q : 17'd0;
			out_q.last           <= 1'b1;
			if (st_sel == ST_STARTED) out_q.transactions <= 14'd0;
			else if (st_sel == ST_EMPTY) out_q.transactions <= commit_inc;
			else out_q.transactions <= commit_cnt_q;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

### rtl/journal_log_replay_sequencer_top.sv
// ----------------------------------------------------------------------------
// journal_log_replay_sequencer_top
// Replays a block journal from its headers: checks the journal start, checks
// each record header, queues valid data writes and emits them on commit.
//
//   channel   signals                               direction
//   input     in_valid, in_ready, in_data           header beats in
//   result    out_valid, out_ready, out_data        result beats out
//   config    cfg_valid, cfg_ready, cfg_index,      register writes in
//             cfg_data
//
// A header beat is captured in the accept state, then checked against the
// replay state in the evaluate state, which loads the result register.
// A commit with queued writes then drains them; each write takes a queue
// memory read step followed by a result load step.
// Reset is asynchronous; the queue memory needs no clearing pass.
// A full result register holds evaluation and drain until its beat is taken.
// ----------------------------------------------------------------------------
module journal_log_replay_sequencer_top #(
	parameter int PENDING_DEPTH       = 64,
	parameter int JOURNAL_BLOCK_COUNT = 16,
	parameter int BLOCK_BYTES         = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  jlrs_pkg::jlrs_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output jlrs_pkg::jlrs_out_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jlrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import jlrs_pkg::*;

	jlrs_cmd_t cmd;
	jlrs_sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer
	jlrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// replay datapath
	jlrs_dp #(
		.PENDING_DEPTH       (PENDING_DEPTH),
		.JOURNAL_BLOCK_COUNT (JOURNAL_BLOCK_COUNT),
		.BLOCK_BYTES         (BLOCK_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

### tb/tb_journal_log_replay_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_journal_log_replay_sequencer_top
// Self-checking bench for the journal replay sequencer. A short table of
// directed headers covers the start checks, target limits, commits and several
// kinds of bad header. Random journals follow under several register settings.
// Every accepted header runs through a replay predictor held in the bench, and
// each result beat is compared field by field with the oldest prediction.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_journal_log_replay_sequencer_top;
	import jlrs_pkg::*;

	localparam int          QUEUE_DEPTH    = 64;
	localparam int          JRNL_BLOCKS    = 16;
	localparam int          BLK_BYTES      = 4096;
	localparam int unsigned JOURNAL_BYTES  = JRNL_BLOCKS * BLK_BYTES;
	localparam int unsigned DATA_REC_BYTES = DATA_HDR_BYTES + BLK_BYTES;
	localparam int          PHASE_COUNT    = 6;
	localparam int          LIVE_PER_PHASE = 85;
	localparam int unsigned CYCLE_LIMIT    = 2000000;

	// register settings walked by the random part
	localparam logic [31:0] SET_JSTART [PHASE_COUNT] =
		'{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'd100, 32'd5, 32'd1};
	localparam logic [31:0] SET_TOTAL [PHASE_COUNT] =
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd200, 32'd0, 32'd1000, 32'd64};

	typedef struct {
		jlrs_in_t  item;
		bit        typed;
		jlrs_out_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	jlrs_in_t    in_data;
	logic        out_valid;
	logic        out_ready;
	jlrs_out_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// replay predictor state
	phase_t      rp_phase;
	logic [16:0] rp_offset;
	logic [31:0] rp_used;
	int          rp_count;
	logic [31:0] rp_blocks [QUEUE_DEPTH];
	logic [16:0] rp_offsets [QUEUE_DEPTH];
	logic [13:0] rp_commits;
	logic [31:0] rp_jstart;
	logic [31:0] rp_total;

	jlrs_out_t   replay_results_due [$];
	int          live_items;
	int          failures;
	int unsigned cycles;
	bit          tx_eager;
	bit          rx_eager;

	journal_log_replay_sequencer_top #(
		.PENDING_DEPTH      (QUEUE_DEPTH),
		.JOURNAL_BLOCK_COUNT(JRNL_BLOCKS),
		.BLOCK_BYTES        (BLK_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("journal_log_replay_sequencer_top test failed");
		$finish;
	end

	// target is usable: non-zero, outside the journal area, below the device size
	function automatic bit target_usable(input logic [31:0] blk);
		longint unsigned b;
		longint unsigned js;
		b  = blk;
		js = rp_jstart;
		if (blk == 32'd0)
			return 1'b0;
		if (b >= js && b < js + JRNL_BLOCKS)
			return 1'b0;
		return blk < rp_total;
	endfunction

	// predict the result beats of one accepted header
	task automatic replay_predict(input jlrs_in_t it);
		jlrs_out_t       r;
		longint unsigned off;
		longint unsigned rsz;
		bit              bad;
		bit              drain;
		r = '0;
		r.last = 1'b1;
		drain = 1'b0;
		off = rp_offset;
		rsz = it.record_size;
		if (it.opcode == OP_START) begin
			if (it.header_magic == JMAGIC && it.header_bytes_used >= JHDR_BYTES &&
					it.header_bytes_used <= JOURNAL_BYTES) begin
				rp_phase   = PH_RUN;
				rp_offset  = 17'(JHDR_BYTES);
				rp_used    = it.header_bytes_used;
				rp_count   = 0;
				rp_commits = '0;
				r.status   = ST_STARTED;
			end else begin
				rp_phase = PH_IDLE;
				rp_count = 0;
				r.status = ST_INVALID;
			end
		end else if (rp_phase != PH_RUN || rp_offset >= rp_used) begin
			r.status = ST_IGNORED;
		end else begin
			bad = (off + RHDR_BYTES > JOURNAL_BYTES) ||
				(it.record_type != RT_DATA && it.record_type != RT_COMMIT) ||
				(it.record_type == RT_DATA && rsz != DATA_REC_BYTES) ||
				(it.record_type == RT_COMMIT && rsz != COMMIT_REC_BYTES) ||
				(rsz == 0) || (off + rsz > rp_used);
			if (bad) begin
				rp_phase = PH_STOP;
				rp_count = 0;
				r.status = ST_STOPPED;
			end else if (it.record_type == RT_DATA) begin
				if (!target_usable(it.target_block)) begin
					rp_offset = 17'(off + rsz);
					r.status  = ST_SKIPPED;
				end else if (rp_count >= QUEUE_DEPTH) begin
					rp_phase = PH_STOP;
					rp_count = 0;
					r.status = ST_OVERFLOW;
				end else begin
					rp_blocks[rp_count]  = it.target_block;
					rp_offsets[rp_count] = 17'(off);
					rp_count++;
					rp_offset        = 17'(off + rsz);
					r.status         = ST_QUEUED;
					r.payload_offset = 17'(off);
				end
			end else begin
				rp_commits = rp_commits + 14'd1;
				rp_offset  = 17'(off + rsz);
				if (rp_count == 0)
					r.status = ST_EMPTY;
				else
					drain = 1'b1;
			end
		end
		r.transactions = rp_commits;
		// a commit with queued writes emits them in queue order
		if (drain) begin
			for (int i = 0; i < rp_count; i++) begin
				r.status         = ST_WRITE;
				r.dest_block     = rp_blocks[i];
				r.payload_offset = rp_offsets[i];
				r.last           = (i + 1 == rp_count);
				replay_results_due.push_back(r);
			end
			rp_count = 0;
			live_items++;
		end else begin
			replay_results_due.push_back(r);
			if (r.status != ST_IGNORED)
				live_items++;
		end
	endtask

	// drive one header beat and predict it once it is taken
	task automatic send_item(input jlrs_in_t it, input bit typed = 1'b0,
			input jlrs_out_t want = '0);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		replay_predict(it);
		if (typed) begin
			void'(replay_results_due.pop_back());
			replay_results_due.push_back(want);
		end
	endtask

	// wait until every predicted beat has come back, then let the block settle
	task automatic wait_drained(input int settle);
		in_valid <= 1'b0;
		while (replay_results_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// write both registers in back-to-back beats
	task automatic write_config(input logic [31:0] jstart, input logic [31:0] total);
		cfg_valid <= 1'b1;
		cfg_index <= REG_JOURNAL_START;
		cfg_data  <= jstart;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rp_jstart = jstart;
		cfg_index <= REG_TOTAL_BLOCKS;
		cfg_data  <= total;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rp_total = total;
		cfg_valid <= 1'b0;
	endtask

	function automatic jlrs_in_t mk_start(input logic [31:0] magic, input logic [31:0] used);
		jlrs_in_t it;
		it.opcode            = OP_START;
		it.header_magic      = magic;
		it.header_bytes_used = used;
		it.record_type       = 16'($urandom);
		it.record_size       = 16'($urandom);
		it.target_block      = $urandom;
		return it;
	endfunction

	function automatic jlrs_in_t mk_rec(input logic [15:0] rtype, input logic [15:0] rsize,
			input logic [31:0] tgt);
		jlrs_in_t it;
		it.opcode            = OP_RECORD;
		it.header_magic      = $urandom;
		it.header_bytes_used = $urandom;
		it.record_type       = rtype;
		it.record_size       = rsize;
		it.target_block      = tgt;
		return it;
	endfunction

	function automatic jlrs_out_t mk_res(input logic [3:0] status);
		jlrs_out_t r;
		r        = '0;
		r.status = status;
		r.last   = 1'b1;
		return r;
	endfunction

	// target picked around the edges of the current register setting
	function automatic logic [31:0] rand_target();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return rp_jstart + $urandom_range(0, JRNL_BLOCKS - 1);
			2: return rp_jstart - 32'd1;
			3: return rp_jstart + JRNL_BLOCKS;
			4: return rp_total - 32'd1;
			5: return rp_total;
			6: return $urandom;
			default: return (rp_total > 32'd1) ? $urandom_range(1, rp_total - 1) : $urandom;
		endcase
	endfunction

	// one journal: valid start, then mostly well-formed records
	task automatic random_journal();
		logic [31:0] used;
		logic [15:0] rtype;
		logic [15:0] rsize;
		int          n_rec;
		int          sel;
		tx_eager = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 9))
			0, 1, 2: used = JOURNAL_BYTES;
			3, 4:    used = $urandom_range(JHDR_BYTES, 4200);
			default: used = $urandom_range(JHDR_BYTES, JOURNAL_BYTES);
		endcase
		send_item(mk_start(JMAGIC, used));
		n_rec = $urandom_range(1, 24);
		for (int k = 0; k < n_rec && rp_phase == PH_RUN; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				send_item(mk_rec(RT_DATA, 16'(DATA_REC_BYTES), rand_target()));
			end else if (sel < 90) begin
				send_item(mk_rec(RT_COMMIT, 16'(COMMIT_REC_BYTES), $urandom));
			end else begin
				// broken header: odd type or size
				case ($urandom_range(0, 2))
					0:       rtype = RT_DATA;
					1:       rtype = RT_COMMIT;
					default: rtype = 16'($urandom);
				endcase
				case ($urandom_range(0, 5))
					0:       rsize = 16'(DATA_REC_BYTES - 1);
					1:       rsize = 16'(DATA_REC_BYTES + 1);
					2:       rsize = 16'd0;
					3:       rsize = 16'(COMMIT_REC_BYTES + 1);
					default: rsize = 16'($urandom);
				endcase
				send_item(mk_rec(rtype, rsize, rand_target()));
			end
		end
	endtask

	// result side: random stalls and field checks
	initial begin
		int        stall_left;
		int        rx_beats;
		jlrs_out_t want;
		stall_left = 0;
		rx_beats   = 0;
		rx_eager   = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (replay_results_due.size() == 0) begin
					$error("unexpected result beat: status %0d, dest_block %0h",
						out_data.status, out_data.dest_block);
					failures++;
				end else begin
					want = replay_results_due.pop_front();
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, out_data.status);
						failures++;
					end
					if (out_data.dest_block !== want.dest_block) begin
						$error("dest_block: expected %0h, actual %0h",
							want.dest_block, out_data.dest_block);
						failures++;
					end
					if (out_data.payload_offset !== want.payload_offset) begin
						$error("payload_offset: expected %0d, actual %0d",
							want.payload_offset, out_data.payload_offset);
						failures++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, out_data.last);
						failures++;
					end
					if (out_data.transactions !== want.transactions) begin
						$error("transactions: expected %0d, actual %0d",
							want.transactions, out_data.transactions);
						failures++;
					end
				end
				rx_beats++;
				if (rx_beats % 40 == 0)
					rx_eager = ($urandom_range(0, 3) == 0);
				stall_left = rx_eager ? 0 : $urandom_range(0, 18);
				if (stall_left > 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (stall_left > 0)
					stall_left--;
				if (stall_left == 0)
					out_ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t rows [$];
		int        live_mark;
		failures   = 0;
		live_items = 0;
		tx_eager   = 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_JOURNAL_START;
		cfg_data  <= '0;
		arst_n    <= 1'b0;

		// predictor in its reset state
		rp_phase   = PH_IDLE;
		rp_offset  = 17'(JHDR_BYTES);
		rp_used    = '0;
		rp_count   = 0;
		rp_commits = '0;
		rp_jstart  = 32'd1;
		rp_total   = 32'd64;

		// directed table under the reset register values
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd17), 1, mk_res(ST_IGNORED)});
		rows.push_back('{mk_start(~JMAGIC, 32'd100), 1, mk_res(ST_INVALID)});
		rows.push_back('{mk_start(JMAGIC, 32'd7), 1, mk_res(ST_INVALID)});
		rows.push_back('{mk_start(JMAGIC, JOURNAL_BYTES + 1), 1, mk_res(ST_INVALID)});
		rows.push_back('{mk_start(JMAGIC, 32'hFFFF_FFFF), 1, mk_res(ST_INVALID)});
		rows.push_back('{mk_start(32'd0, 32'd0), 1, mk_res(ST_INVALID)});
		// smallest journal: nothing past its header
		rows.push_back('{mk_start(JMAGIC, 32'd8), 1, mk_res(ST_STARTED)});
		rows.push_back('{mk_rec(RT_COMMIT, 16'(COMMIT_REC_BYTES), 32'd0), 1,
			mk_res(ST_IGNORED)});
		// target limits: zero, journal area ends, device end, all ones
		rows.push_back('{mk_start(JMAGIC, JOURNAL_BYTES), 1, mk_res(ST_STARTED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd0), 1, mk_res(ST_SKIPPED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd1), 1, mk_res(ST_SKIPPED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd16), 1, mk_res(ST_SKIPPED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd64), 1, mk_res(ST_SKIPPED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'hFFFF_FFFF), 1,
			mk_res(ST_SKIPPED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd17), 0, '0});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd63), 0, '0});
		rows.push_back('{mk_rec(RT_COMMIT, 16'(COMMIT_REC_BYTES), 32'd0), 0, '0});
		rows.push_back('{mk_rec(RT_COMMIT, 16'(COMMIT_REC_BYTES), 32'd0), 0, '0});
		// wrong exact size stops the replay, later records are ignored
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES - 1), 32'd20), 0, '0});
		rows.push_back('{mk_rec(RT_COMMIT, 16'(COMMIT_REC_BYTES), 32'd0), 0, '0});
		// unknown type discards the queue
		rows.push_back('{mk_start(JMAGIC, JOURNAL_BYTES), 1, mk_res(ST_STARTED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd40), 0, '0});
		rows.push_back('{mk_rec(16'd0, 16'(COMMIT_REC_BYTES), 32'd0), 1, mk_res(ST_STOPPED)});
		// zero size
		rows.push_back('{mk_start(JMAGIC, 32'd20), 1, mk_res(ST_STARTED)});
		rows.push_back('{mk_rec(RT_COMMIT, 16'd0, 32'd0), 1, mk_res(ST_STOPPED)});
		// record running past the used end
		rows.push_back('{mk_start(JMAGIC, 32'd4110), 1, mk_res(ST_STARTED)});
		rows.push_back('{mk_rec(RT_DATA, 16'(DATA_REC_BYTES), 32'd40), 1, mk_res(ST_STOPPED)});
		// all-ones header
		rows.push_back('{mk_start(JMAGIC, JOURNAL_BYTES), 1, mk_res(ST_STARTED)});
		rows.push_back('{mk_rec(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1, mk_res(ST_STOPPED)});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].item, rows[i].typed, rows[i].want);

		// random journals under each register setting
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_drained(8);
			write_config(SET_JSTART[p], SET_TOTAL[p]);
			live_mark = live_items;
			while (live_items - live_mark < LIVE_PER_PHASE) begin
				if ($urandom_range(0, 99) < 12) begin
					// noise beat with every field random
					tx_eager = 1'b0;
					send_item('{opcode: 1'($urandom), header_magic: $urandom,
						header_bytes_used: $urandom, record_type: 16'($urandom),
						record_size: 16'($urandom), target_block: $urandom});
				end else begin
					random_journal();
				end
			end
		end

		wait_drained(40);
		if (failures == 0)
			$display("journal_log_replay_sequencer_top test passed");
		else
			$display("journal_log_replay_sequencer_top test failed");
		$finish;
	end

endmodule
